### rtl/byte_queue_peek_drop_macros.svh
// assertion macros shared by the byte queue rtl
`ifndef BYTE_QUEUE_PEEK_DROP_MACROS_SVH
`define BYTE_QUEUE_PEEK_DROP_MACROS_SVH

// property must hold at every clock edge out of reset
`define BQPD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition must never be seen out of reset
`define BQPD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

### rtl/bqpd_pkg.sv
// shared types, codes and defaults of the byte queue
`default_nettype none

package bqpd_pkg;

    localparam int STORE_DEPTH_DEF = 1024;
    localparam int MAX_REQUEST_DEF = 64;

    localparam int REQ_TYPE_W = 2;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 11;
    localparam int ENTRY_W    = BYTE_W + 1;

    localparam logic [REQ_TYPE_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEQ  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_PEEK = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_DROP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [BYTE_W-1:0]     in_byte;
        logic                  ends_buffer;
        logic [COUNT_W-1:0]    byte_count;
    } bqpd_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic                last_result;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  queued_bytes;
        logic [TOTAL_W-1:0]  queued_buffers;
    } bqpd_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_EMIT,
        S_DROP_RES
    } bqpd_state_t;

    typedef struct packed {
        logic enq;
        logic start;
        logic empty_res;
        logic run;
        logic emit;
        logic commit;
        logic drop_res;
    } bqpd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic take_zero;
        logic last_ret;
        logic drop_req;
    } bqpd_stat_t;

endpackage

`default_nettype wire

### rtl/bqpd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module bqpd_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/bqpd_ctrl.sv
// request sequencer of the byte queue
`default_nettype none

`include "byte_queue_peek_drop_macros.svh"

module bqpd_ctrl
    import bqpd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [REQ_TYPE_W-1:0] req_type,
    input  wire bqpd_stat_t            stat,
    output bqpd_cmd_t                  cmd
);

    bqpd_state_t state_reg;
    bqpd_state_t state_next;
    logic        accept;

    assign s_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (req_type != REQ_ENQ) && !stat.take_zero) begin
                    state_next = (req_type == REQ_PEEK) ? S_EMIT : S_COUNT;
                end
            end
            S_COUNT: begin
                if (stat.last_ret) begin
                    state_next = stat.drop_req ? S_DROP_RES : S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.last_ret) begin
                    state_next = S_IDLE;
                end
            end
            S_DROP_RES: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd           = '0;
        cmd.enq       = accept && (req_type == REQ_ENQ);
        cmd.start     = accept && (req_type != REQ_ENQ);
        cmd.empty_res = accept && (req_type != REQ_ENQ) && stat.take_zero;
        cmd.run       = (state_reg == S_COUNT) || (state_reg == S_EMIT);
        cmd.emit      = (state_reg == S_EMIT);
        cmd.commit    = (state_reg == S_COUNT) && stat.last_ret;
        cmd.drop_res  = (state_reg == S_DROP_RES) && stat.out_free;
    end

    `BQPD_ASSERT(a_drop_after_count, aclk, aresetn, (state_reg == S_DROP_RES) |-> ($past(state_reg) == S_COUNT || $past(state_reg) == S_DROP_RES), "drop result state entered without count pass")

endmodule

`default_nettype wire

### rtl/bqpd_dp.sv
// byte queue datapath: store, pointers, totals, read pass and result register
`default_nettype none

`include "byte_queue_peek_drop_macros.svh"

module bqpd_dp
    import bqpd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire bqpd_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output bqpd_out_t      m_data,
    input  wire bqpd_cmd_t cmd,
    output bqpd_stat_t     stat
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(STORE_DEPTH - 1);
    localparam logic [CNT_W-1:0]   FULL_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [COUNT_W-1:0] MAX_REQ  = COUNT_W'(MAX_REQUEST);

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    function automatic bqpd_out_t make_res(
        input logic [BYTE_W-1:0]   b,
        input logic                valid,
        input logic                last,
        input logic [STATUS_W-1:0] st,
        input logic [CNT_W-1:0]    nbytes,
        input logic [CNT_W-1:0]    nbufs
    );
        bqpd_out_t r;
        r.out_byte       = b;
        r.byte_valid     = valid;
        r.last_result    = last;
        r.status         = st;
        r.queued_bytes   = TOTAL_W'(nbytes);
        r.queued_buffers = TOTAL_W'(nbufs);
        return r;
    endfunction

    logic [IDX_W-1:0]      head_reg, head_next;
    logic [IDX_W-1:0]      tail_reg, tail_next;
    logic [IDX_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      byte_total_reg, byte_total_next;
    logic [CNT_W-1:0]      buffer_total_reg, buffer_total_next;
    logic                  buffer_open_reg, buffer_open_next;
    logic [REQ_TYPE_W-1:0] req_reg, req_next;
    logic [COUNT_W-1:0]    take_reg, take_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [COUNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic [COUNT_W-1:0]    ret_cnt_reg, ret_cnt_next;
    logic                  rdv_reg, rdv_next;
    logic                  m_valid_reg, m_valid_next;
    bqpd_out_t             m_data_reg, m_data_next;

    logic [COUNT_W-1:0]  want;
    logic                short_req;
    logic [COUNT_W-1:0]  take_new;
    logic [STATUS_W-1:0] status_new;
    logic                full;
    logic                out_free;
    logic                consume;
    logic                issue;
    logic                last_ret;
    logic                wr_en;
    logic [ENTRY_W-1:0]  wr_entry;
    logic [ENTRY_W-1:0]  rd_entry;

    bqpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    // request size against what is held
    assign want       = (s_data.byte_count > MAX_REQ) ? MAX_REQ : s_data.byte_count;
    assign short_req  = CMP_W'(want) > CMP_W'(byte_total_reg);
    assign take_new   = short_req ? COUNT_W'(byte_total_reg) : want;
    assign status_new = short_req ? ST_SHORT : ST_OK;
    assign full       = (byte_total_reg == FULL_CNT);

    // read pass: ram data reg holds a byte until it is used
    assign out_free = !m_valid_reg || m_ready;
    assign consume  = cmd.run && rdv_reg && (!cmd.emit || out_free);
    assign issue    = cmd.run && (iss_cnt_reg != take_reg) && (!rdv_reg || consume);
    assign last_ret = consume && (ret_cnt_reg == (take_reg - 1'b1));

    assign wr_entry = {s_data.ends_buffer, s_data.in_byte};
    assign wr_en    = cmd.enq && !full;

    assign stat.out_free  = out_free;
    assign stat.take_zero = (take_new == '0);
    assign stat.last_ret  = last_ret;
    assign stat.drop_req  = (req_reg == REQ_DROP);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        head_next         = head_reg;
        tail_next         = tail_reg;
        rd_ptr_next       = rd_ptr_reg;
        byte_total_next   = byte_total_reg;
        buffer_total_next = buffer_total_reg;
        buffer_open_next  = buffer_open_reg;
        req_next          = req_reg;
        take_next         = take_reg;
        status_next       = status_reg;
        iss_cnt_next      = iss_cnt_reg;
        ret_cnt_next      = ret_cnt_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_data_next       = m_data_reg;

        if (cmd.enq) begin
            if (!full) begin
                tail_next       = wrap_inc(tail_reg);
                byte_total_next = byte_total_reg + 1'b1;
                if (!buffer_open_reg) begin
                    buffer_total_next = buffer_total_reg + 1'b1;
                end
                buffer_open_next = !s_data.ends_buffer;
            end
            m_valid_next = 1'b1;
            m_data_next  = make_res('0, 1'b0, 1'b1, full ? ST_FULL : ST_OK,
                                    byte_total_next, buffer_total_next);
        end

        if (cmd.start) begin
            req_next     = s_data.req_type;
            take_next    = take_new;
            status_next  = status_new;
            rd_ptr_next  = head_reg;
            iss_cnt_next = '0;
            ret_cnt_next = '0;
        end

        if (cmd.empty_res) begin
            m_valid_next = 1'b1;
            m_data_next  = make_res('0, 1'b0, 1'b1, status_new,
                                    byte_total_reg, buffer_total_reg);
        end

        if (issue) begin
            iss_cnt_next = iss_cnt_reg + 1'b1;
            rd_ptr_next  = wrap_inc(rd_ptr_reg);
        end

        if (consume) begin
            ret_cnt_next = ret_cnt_reg + 1'b1;
            if (cmd.emit) begin
                m_valid_next = 1'b1;
                m_data_next  = make_res(rd_entry[BYTE_W-1:0], 1'b1, last_ret, status_reg,
                                        byte_total_reg, buffer_total_reg);
            end else if (rd_entry[BYTE_W] && (buffer_total_reg != '0)) begin
                buffer_total_next = buffer_total_reg - 1'b1;
            end
        end

        // end of count pass: remove the bytes, rewind for the emit pass
        if (cmd.commit) begin
            head_next       = rd_ptr_reg;
            byte_total_next = byte_total_reg - CNT_W'(take_reg);
            rd_ptr_next     = head_reg;
            iss_cnt_next    = '0;
            ret_cnt_next    = '0;
        end

        if (cmd.drop_res) begin
            m_valid_next = 1'b1;
            m_data_next  = make_res('0, 1'b0, 1'b1, status_reg,
                                    byte_total_reg, buffer_total_reg);
        end
    end

    assign rdv_next = issue ? 1'b1 : (consume ? 1'b0 : rdv_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg         <= '0;
            tail_reg         <= '0;
            rd_ptr_reg       <= '0;
            byte_total_reg   <= '0;
            buffer_total_reg <= '0;
            buffer_open_reg  <= 1'b0;
            req_reg          <= REQ_ENQ;
            take_reg         <= '0;
            status_reg       <= ST_OK;
            iss_cnt_reg      <= '0;
            ret_cnt_reg      <= '0;
            rdv_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            rd_ptr_reg       <= rd_ptr_next;
            byte_total_reg   <= byte_total_next;
            buffer_total_reg <= buffer_total_next;
            buffer_open_reg  <= buffer_open_next;
            req_reg          <= req_next;
            take_reg         <= take_next;
            status_reg       <= status_next;
            iss_cnt_reg      <= iss_cnt_next;
            ret_cnt_reg      <= ret_cnt_next;
            rdv_reg          <= rdv_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `BQPD_NEVER(a_total_bound, aclk, aresetn, byte_total_reg > FULL_CNT, "byte total above store depth")
    `BQPD_NEVER(a_issue_bound, aclk, aresetn, iss_cnt_reg > take_reg, "more reads issued than taken")
    `BQPD_ASSERT(a_read_balance, aclk, aresetn, (COUNT_W'(ret_cnt_reg + COUNT_W'(rdv_reg)) == iss_cnt_reg), "read pass lost or invented a byte")

endmodule

`default_nettype wire

### rtl/byte_queue_peek_drop.sv
// an enqueue result is registered, shown in the cycle after accept; a peek goes through the
// state, ram read and result registers to its first byte; dequeue and drop first scan the
// taken bytes for buffer ends, then dequeue streams one byte per cycle while results are
// taken and drop gives its single result once the result channel is free; throughput: one
// enqueue per cycle while results are taken; a read request holds the block until it is done
// reset: synchronous active low, clears pointers and totals; store contents are kept
`default_nettype none

module byte_queue_peek_drop
    import bqpd_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    // request channel
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire bqpd_in_t s_data,
    // result channel
    output logic          m_valid,
    input  wire logic     m_ready,
    output bqpd_out_t     m_data
);

    // command and status between sequencer and datapath
    bqpd_cmd_t  cmd;
    bqpd_stat_t stat;

    // sequencer: idle / count pass / emit pass / drop result
    bqpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_data.req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: byte store, head and tail pointers, totals and result register
    bqpd_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

### verif/tb_byte_queue_peek_drop.sv
// testbench for the byte queue: directed and random requests checked against a scoreboard
`timescale 1ns / 100ps

module tb_byte_queue_peek_drop
    import bqpd_pkg::*;
();

    localparam int DEPTH    = STORE_DEPTH_DEF;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int MAX_REQ  = MAX_REQUEST_DEF;
    // quiet cycles after the last expected result, to catch stray results
    localparam int SETTLE_CYCLES = 300;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bqpd_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bqpd_out_t m_data;

    // requests waiting to be driven, results waiting to be seen
    bqpd_in_t  request_backlog[$];
    bqpd_out_t pending_results[$];

    // shadow copy of the queue contents and totals
    logic [ENTRY_W-1:0] shadow_store [DEPTH];
    int   shadow_head    = 0;
    int   shadow_tail    = 0;
    int   held_bytes     = 0;
    int   held_buffers   = 0;
    logic buffer_growing = 1'b0;

    int   error_count = 0;
    int   cycle_count = 0;
    logic req_fired   = 1'b0;

    // periodic stretch in which neither side idles
    wire  calm = (cycle_count % 1000) >= 800;

    byte_queue_peek_drop #(
        .STORE_DEPTH (DEPTH),
        .MAX_REQUEST (MAX_REQ)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // append to the tail of the request and result queues
    function automatic void add_request(input bqpd_in_t r);
        request_backlog.insert(request_backlog.size(), r);
    endfunction

    function automatic void add_result(input bqpd_out_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // work out the results of one accepted request and update the shadow queue
    task automatic predict_request(input bqpd_in_t req);
        bqpd_out_t       res;
        int              want;
        int              take;
        int              idx;
        logic [1:0]      st;
        logic [BYTE_W-1:0] taken[$];
        res = '0;
        res.last_result = 1'b1;
        if (req.req_type == REQ_ENQ) begin
            if (held_bytes >= DEPTH) begin
                // store full, request rejected
                res.status = ST_FULL;
            end else begin
                shadow_store[IDX_W'(shadow_tail)] = {req.ends_buffer, req.in_byte};
                shadow_tail = (shadow_tail + 1) % DEPTH;
                held_bytes++;
                // first byte of a buffer opens a new one
                if (!buffer_growing) begin
                    held_buffers++;
                end
                buffer_growing = !req.ends_buffer;
                res.status = ST_OK;
            end
            res.queued_bytes   = TOTAL_W'(held_bytes);
            res.queued_buffers = TOTAL_W'(held_buffers);
            add_result(res);
        end else begin
            // oversized counts saturate
            want = (req.byte_count > MAX_REQ) ? MAX_REQ : int'(req.byte_count);
            take = (want < held_bytes) ? want : held_bytes;
            st   = (take < want) ? ST_SHORT : ST_OK;
            idx  = shadow_head;
            for (int i = 0; i < take; i++) begin
                taken.insert(taken.size(), shadow_store[IDX_W'(idx)][BYTE_W-1:0]);
                // a buffer leaves the count once its end byte is removed
                if (req.req_type != REQ_PEEK && shadow_store[IDX_W'(idx)][BYTE_W] &&
                    held_buffers > 0) begin
                    held_buffers--;
                end
                idx = (idx + 1) % DEPTH;
            end
            if (req.req_type != REQ_PEEK) begin
                shadow_head = idx;
                held_bytes -= take;
            end
            res.status         = st;
            res.queued_bytes   = TOTAL_W'(held_bytes);
            res.queued_buffers = TOTAL_W'(held_buffers);
            if (req.req_type == REQ_DROP || take == 0) begin
                add_result(res);
            end else begin
                res.byte_valid = 1'b1;
                for (int i = 0; i < take; i++) begin
                    res.out_byte    = taken[i];
                    res.last_result = (i == take - 1);
                    add_result(res);
                end
            end
        end
    endtask

    task automatic flag_error(input string why, input bqpd_out_t exp_res,
                              input bqpd_out_t got_res);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t %s: exp byte=%02h v=%0d last=%0d st=%0d qb=%0d qbuf=%0d",
                     $realtime, why, exp_res.out_byte, exp_res.byte_valid,
                     exp_res.last_result, exp_res.status, exp_res.queued_bytes,
                     exp_res.queued_buffers);
            $display("%0t %s: got byte=%02h v=%0d last=%0d st=%0d qb=%0d qbuf=%0d",
                     $realtime, why, got_res.out_byte, got_res.byte_valid,
                     got_res.last_result, got_res.status, got_res.queued_bytes,
                     got_res.queued_buffers);
        end
    endtask

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            // present the next request once the current one is gone
            if (!s_valid || req_fired) begin
                if (request_backlog.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
                    s_data  <= request_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 33);
        end
    end

    // monitor: both channels sampled on the rising edge
    always @(posedge aclk) begin
        bqpd_out_t exp_res;
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            req_fired   <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                predict_request(s_data);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    flag_error("unexpected result", '0, m_data);
                end else begin
                    exp_res = pending_results.pop_front();
                    if (m_data.out_byte       !== exp_res.out_byte ||
                        m_data.byte_valid     !== exp_res.byte_valid ||
                        m_data.last_result    !== exp_res.last_result ||
                        m_data.status         !== exp_res.status ||
                        m_data.queued_bytes   !== exp_res.queued_bytes ||
                        m_data.queued_buffers !== exp_res.queued_buffers) begin
                        flag_error("result mismatch", exp_res, m_data);
                    end
                end
            end
        end
    end

    // enqueue request; the unused count field carries noise
    function automatic bqpd_in_t enq_req(input logic [BYTE_W-1:0] b, input logic ends);
        bqpd_in_t r;
        r.req_type    = REQ_ENQ;
        r.in_byte     = b;
        r.ends_buffer = ends;
        r.byte_count  = COUNT_W'($urandom_range(0, 127));
        return r;
    endfunction

    // dequeue, peek or drop; unused byte fields carry noise
    function automatic bqpd_in_t read_req(input logic [REQ_TYPE_W-1:0] kind, input int n);
        bqpd_in_t r;
        r.req_type    = kind;
        r.in_byte     = BYTE_W'($urandom_range(0, 255));
        r.ends_buffer = 1'($urandom_range(0, 1));
        r.byte_count  = COUNT_W'(n);
        return r;
    endfunction

    initial begin
        int n_items;
        int len;
        logic [REQ_TYPE_W-1:0] kind;

        // reads on an empty queue, short and zero counts
        add_request(read_req(REQ_PEEK, 5));
        add_request(read_req(REQ_DEQ, 1));
        add_request(read_req(REQ_DROP, 64));
        add_request(read_req(REQ_DEQ, 0));
        add_request(read_req(REQ_PEEK, 0));
        add_request(read_req(REQ_DROP, 0));
        // one closed buffer of three bytes, then an open one
        add_request(enq_req(8'h00, 1'b0));
        add_request(enq_req(8'hff, 1'b0));
        add_request(enq_req(8'ha5, 1'b1));
        add_request(enq_req(8'h5a, 1'b0));
        // oversized peek saturates, then partial peeks
        add_request(read_req(REQ_PEEK, 127));
        add_request(read_req(REQ_PEEK, 2));
        add_request(read_req(REQ_PEEK, 64));
        // take the closed buffer, then drain the open one: it stays counted
        add_request(read_req(REQ_DEQ, 3));
        add_request(read_req(REQ_DROP, 1));
        add_request(enq_req(8'hc3, 1'b1));
        add_request(read_req(REQ_DEQ, 64));
        // zero counts with data held
        add_request(enq_req(8'h81, 1'b1));
        add_request(read_req(REQ_DEQ, 0));
        add_request(read_req(REQ_DROP, 0));
        add_request(read_req(REQ_PEEK, 0));
        add_request(read_req(REQ_DROP, 1));

        // random part: mostly whole buffers and reads, some open buffers and odd counts
        n_items = 0;
        while (n_items < 230) begin
            if ($urandom_range(99) < 50) begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++) begin
                    add_request(enq_req(BYTE_W'($urandom_range(0, 255)),
                        (j == len - 1) && ($urandom_range(0, 5) != 0)));
                end
                n_items += len;
            end else begin
                kind = REQ_TYPE_W'($urandom_range(1, 3));
                if ($urandom_range(0, 7) == 0) begin
                    add_request(read_req(kind, $urandom_range(0, 127)));
                end else begin
                    add_request(read_req(kind, $urandom_range(1, 12)));
                end
                n_items++;
            end
        end

        // synchronous reset held at the start, then released on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all requests accepted, then all results seen, then a quiet spell
        while (request_backlog.size() != 0 || s_valid) @(negedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("** byte_queue_peek_drop: PASSED **");
        end else begin
            $display("** byte_queue_peek_drop: FAILED **");
        end
        $finish;
    end

    // watchdog
    initial begin
        #15_000_000;
        $display("** byte_queue_peek_drop: FAILED **");
        $finish;
    end

endmodule
